// ----- rtl/s2c_pkg.sv -----
// Shared types, constants and calendar helpers for the seconds-to-date converter.
`default_nettype none

package s2c_pkg;

  localparam int unsigned LATENCY = 7;

  localparam logic [31:0] RECIP_60  = 32'h8888_8889;
  localparam logic [31:0] RECIP_24  = 32'hAAAA_AAAB;
  localparam logic [16:0] RECIP_365 = 17'd91930;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [7:0]  NONLEAP_YOFF  = 8'd100;
  localparam logic [11:0] EPOCH_YEAR    = 12'd2000;
  localparam logic [8:0]  LEAP_DAY_DOY  = 9'd59;
  localparam logic [3:0]  FEBRUARY      = 4'd2;
  localparam logic [4:0]  LEAP_DAY_DOM  = 5'd29;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  function automatic logic is_leap(input logic [7:0] yoff);
    return (yoff[1:0] == 2'b00) && (yoff != NONLEAP_YOFF);
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/s2c_clock.sv -----
// Four-stage split of a seconds count into day number and time of day.
`default_nettype none

module s2c_clock
  import s2c_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [31:0] seconds_count,
  output logic             out_valid,
  output logic [15:0]      days,
  output tod_t             tod
);

  logic        v1, v2, v3;
  logic [63:0] p1;
  logic [31:0] t1;
  logic [26:0] q1;
  logic [5:0]  sec2, sec3;
  logic [58:0] p2;
  logic [20:0] q2;
  logic [5:0]  min3;
  logic [52:0] p3;

  logic [63:0] p1_next;
  logic [26:0] q1_next;
  logic [32:0] q1_x60;
  logic [5:0]  sec2_next;
  logic [58:0] p2_next;
  logic [20:0] q2_next;
  logic [26:0] q2_x60;
  logic [5:0]  min3_next;
  logic [52:0] p3_next;
  logic [15:0] days_next;
  logic [19:0] days_x24;
  logic [4:0]  hour_next;

  always_comb begin
    p1_next   = 64'(seconds_count) * 64'(RECIP_60);
    q1_next   = p1[63:37];
    q1_x60    = {q1_next, 6'd0} - {4'd0, q1_next, 2'd0};
    sec2_next = t1[5:0] - q1_x60[5:0];
    p2_next   = 59'(q1_next) * 59'(RECIP_60);
    q2_next   = p2[57:37];
    q2_x60    = {q2_next, 6'd0} - {4'd0, q2_next, 2'd0};
    min3_next = q1[5:0] - q2_x60[5:0];
    p3_next   = 53'(q2_next) * 53'(RECIP_24);
    days_next = p3[51:36];
    days_x24  = {days_next, 4'd0} + {1'b0, days_next, 3'd0};
    hour_next = q2[4:0] - days_x24[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    p1         <= p1_next;
    t1         <= seconds_count;
    q1         <= q1_next;
    sec2       <= sec2_next;
    p2         <= p2_next;
    q2         <= q2_next;
    min3       <= min3_next;
    sec3       <= sec2;
    p3         <= p3_next;
    days       <= days_next;
    tod.hour   <= hour_next;
    tod.minute <= min3;
    tod.second <= sec3;
  end

endmodule

`default_nettype wire

// ----- rtl/s2c_date.sv -----
// Three-stage split of a day number into year, month and day of month.
`default_nettype none

module s2c_date
  import s2c_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [15:0] days,
  output logic             out_valid,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day
);

  logic        v5, v6;
  logic [32:0] p5;
  logic [15:0] d5;
  logic [7:0]  yoff6;
  logic [8:0]  doy6;

  logic [32:0] p5_next;
  logic [7:0]  yraw;
  logic [7:0]  yprev;
  logic [16:0] y_x365;
  logic [15:0] doy_wide;
  logic [8:0]  doy_raw;
  logic [8:0]  lb_q;
  logic [5:0]  lb;
  logic [9:0]  doy_wrap;
  logic [7:0]  yoff6_next;
  logic [8:0]  doy6_next;

  logic        leap;
  logic [8:0]  d;
  logic [8:0]  base;
  logic [8:0]  dom_wide;
  logic [3:0]  month_next;
  logic [4:0]  day_next;

  always_comb begin
    p5_next  = 33'(days) * 33'(RECIP_365);
    yraw     = p5[32:25];
    yprev    = yraw - 8'd1;
    y_x365   = 17'(yraw) * 17'(DAYS_PER_YEAR);
    doy_wide = d5 - y_x365[15:0];
    doy_raw  = doy_wide[8:0];
    lb_q     = (9'(yraw) + 9'd3) >> 2;
    lb       = lb_q[5:0] - {5'd0, (yraw > NONLEAP_YOFF)};
    doy_wrap = 10'(doy_raw) + 10'(DAYS_PER_YEAR) + {9'd0, is_leap(yprev)} - 10'(lb);
    if (doy_raw < 9'(lb)) begin
      yoff6_next = yprev;
      doy6_next  = doy_wrap[8:0];
    end else begin
      yoff6_next = yraw;
      doy6_next  = doy_raw - 9'(lb);
    end
  end

  always_comb begin
    leap = is_leap(yoff6);
    d    = doy6;
    if (leap && (doy6 > LEAP_DAY_DOY)) begin
      d = doy6 - 9'd1;
    end
    month_next = 4'd1;
    base       = 9'd0;
    for (int i = 1; i < 12; i++) begin
      if (d >= month_start(4'(i))) begin
        month_next = 4'(i + 1);
        base       = month_start(4'(i));
      end
    end
    dom_wide = d - base + 9'd1;
    day_next = dom_wide[4:0];
    if (leap && (doy6 == LEAP_DAY_DOY)) begin
      month_next = FEBRUARY;
      day_next   = LEAP_DAY_DOM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v5        <= in_valid;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    p5    <= p5_next;
    d5    <= days;
    yoff6 <= yoff6_next;
    doy6  <= doy6_next;
    year  <= EPOCH_YEAR + 12'(yoff6);
    month <= month_next;
    day   <= day_next;
  end

endmodule

`default_nettype wire

// ----- rtl/seconds_to_calendar_date.sv -----
// Top level of the pipelined converter from a seconds count to a calendar date and time.
//
//   channel   direction  handshake         fields
//   command   in         start / busy      seconds_count
//   result    out        done (one cycle)  year, month, day, hour, minute, second
//
// A command beat is taken on any edge with start high and busy low; busy is high
// only during reset, so a new count can enter on every cycle.
// Each result passes the clock split and then the date split, its latency set by the chain of
// reciprocal multiplies (three in the time split, one for the year) and their fix-ups.
// Reset clears the stage valid bits; counts in flight are dropped.
// The result side cannot stall, so the pipeline never holds.
`default_nettype none

module seconds_to_calendar_date
  import s2c_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] seconds_count,
  output logic             done,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second
);

  logic        clk_valid;
  logic [15:0] days;
  tod_t        tod;
  tod_t        tod5, tod6, tod7;

  assign busy = rst;

  s2c_clock u_clock (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .seconds_count (seconds_count),
    .out_valid     (clk_valid),
    .days          (days),
    .tod           (tod)
  );

  s2c_date u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (clk_valid),
    .days      (days),
    .out_valid (done),
    .year      (year),
    .month     (month),
    .day       (day)
  );

  always_ff @(posedge clk) begin
    tod5 <= tod;
    tod6 <= tod5;
    tod7 <= tod6;
  end

  assign hour   = tod7.hour;
  assign minute = tod7.minute;
  assign second = tod7.second;

endmodule

`default_nettype wire

// ----- rtl/s2c_checker.sv -----
// Port-level assertions for the converter, bound to its top level.
`default_nettype none

module s2c_checker
  import s2c_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [11:0] year,
  input wire logic [3:0]  month,
  input wire logic [4:0]  day,
  input wire logic [4:0]  hour,
  input wire logic [5:0]  minute,
  input wire logic [5:0]  second
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted beat");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 &&
              year >= 12'd2000 && year <= 12'd2136 &&
              (month != FEBRUARY || day <= LEAP_DAY_DOM)))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour < 5'd24 && minute < 6'd60 && second < 6'd60))
    else $error("time field out of range");

endmodule

bind seconds_to_calendar_date s2c_checker u_s2c_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .year   (year),
  .month  (month),
  .day    (day),
  .hour   (hour),
  .minute (minute),
  .second (second)
);

`default_nettype wire
